// ===== src/tcce_pkg.sv =====
// Shared constants, types and command/status bundles for the text console cursor engine.
package tcce_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int TCNT_W = $clog2(TAB_STOP + 1);

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
    localparam logic [CHAR_W-1:0] CLEAR_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_SCREEN = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_CLEAR,
        CLS_NEWLINE,
        CLS_RETURN,
        CLS_BACKSPACE,
        CLS_TAB
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_BKSP,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic newline;
        logic cret;
        logic clear;
        logic bksp;
        logic put;
        logic scroll;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        class_t cls;
        logic   out_free;
        logic   col_zero;
        logic   row_last;
        logic   put_scroll;
        logic   tab_more;
    } sts_t;

endpackage

// ===== src/tcce_ctrl.sv =====
// Sequencing state machine of the text console cursor engine.
module tcce_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tcce_pkg::sts_t sts,
    output tcce_pkg::cmd_t cmd
);

    tcce_pkg::state_t state_reg;
    tcce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.cls)
                        tcce_pkg::CLS_CLEAR:
                            state_next = tcce_pkg::ST_CLEAR;
                        tcce_pkg::CLS_NEWLINE:
                            state_next = sts.row_last ? tcce_pkg::ST_SCROLL
                                                      : tcce_pkg::ST_IDLE;
                        tcce_pkg::CLS_RETURN:
                            state_next = tcce_pkg::ST_IDLE;
                        tcce_pkg::CLS_BACKSPACE:
                            state_next = sts.col_zero ? tcce_pkg::ST_IDLE
                                                      : tcce_pkg::ST_BKSP;
                        default:
                            state_next = tcce_pkg::ST_PUT;
                    endcase
                end
            end
            tcce_pkg::ST_PUT:
            begin
                if (sts.out_free)
                begin
                    if (sts.put_scroll)
                    begin
                        state_next = tcce_pkg::ST_SCROLL;
                    end
                    else if (sts.tab_more)
                    begin
                        state_next = tcce_pkg::ST_PUT;
                    end
                    else
                    begin
                        state_next = tcce_pkg::ST_IDLE;
                    end
                end
            end
            tcce_pkg::ST_BKSP,
            tcce_pkg::ST_SCROLL,
            tcce_pkg::ST_CLEAR:
            begin
                if (sts.out_free)
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.accept  = in_valid;
                cmd.newline = in_valid && (sts.cls == tcce_pkg::CLS_NEWLINE);
                cmd.cret    = in_valid && (sts.cls == tcce_pkg::CLS_RETURN);
            end
            tcce_pkg::ST_PUT:    cmd.put    = sts.out_free;
            tcce_pkg::ST_BKSP:   cmd.bksp   = sts.out_free;
            tcce_pkg::ST_SCROLL: cmd.scroll = sts.out_free;
            tcce_pkg::ST_CLEAR:  cmd.clear  = sts.out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/tcce_dp.sv =====
// Cursor, offset and output registers of the text console cursor engine.
module tcce_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           op,
    input  logic [tcce_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcce_pkg::CHAR_W-1:0]    attr,
    input  tcce_pkg::cmd_t                 cmd,
    output tcce_pkg::sts_t                 sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [tcce_pkg::ROW_W-1:0]     row,
    output logic [tcce_pkg::COL_W-1:0]     col,
    output logic [tcce_pkg::CHAR_W-1:0]    glyph,
    output logic [tcce_pkg::CHAR_W-1:0]    cell_attr,
    output logic [tcce_pkg::ROW_W-1:0]     top_row,
    output logic                           last
);

    localparam logic [tcce_pkg::ROW_W-1:0] ROW_MAX = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
    localparam logic [tcce_pkg::COL_W-1:0] COL_MAX = tcce_pkg::COL_W'(tcce_pkg::COLS - 1);

    logic [tcce_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcce_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tcce_pkg::ROW_W-1:0]  top_reg, top_next;
    logic [tcce_pkg::CHAR_W-1:0] attr_reg;
    logic [tcce_pkg::CHAR_W-1:0] glyph_reg;
    logic                        is_tab_reg;
    logic [tcce_pkg::TCNT_W-1:0] tcnt_reg, tcnt_next;

    logic                        ovalid_reg, ovalid_next;
    tcce_pkg::kind_t             okind_reg;
    logic [tcce_pkg::ROW_W-1:0]  orow_reg;
    logic [tcce_pkg::COL_W-1:0]  ocol_reg;
    logic [tcce_pkg::CHAR_W-1:0] oglyph_reg;
    logic [tcce_pkg::CHAR_W-1:0] oattr_reg;
    logic [tcce_pkg::ROW_W-1:0]  otop_reg;
    logic                        olast_reg;

    tcce_pkg::class_t            cls;
    logic [tcce_pkg::ROW_W:0]    phys_sum;
    logic [tcce_pkg::ROW_W-1:0]  phys;
    logic [tcce_pkg::COL_W-1:0]  col_dec;
    logic                        wrap;
    logic [tcce_pkg::COL_W-1:0]  col_after;
    logic                        tab_more;
    logic                        put_scroll;
    logic [tcce_pkg::ROW_W-1:0]  top_adv;
    logic                        emit;

    // Classify the input item straight from the ports.
    always_comb
    begin
        if (op)
        begin
            cls = tcce_pkg::CLS_CLEAR;
        end
        else
        begin
            case (char_code)
                tcce_pkg::CH_NEWLINE:   cls = tcce_pkg::CLS_NEWLINE;
                tcce_pkg::CH_RETURN:    cls = tcce_pkg::CLS_RETURN;
                tcce_pkg::CH_BACKSPACE: cls = tcce_pkg::CLS_BACKSPACE;
                tcce_pkg::CH_TAB:       cls = tcce_pkg::CLS_TAB;
                default:                cls = tcce_pkg::CLS_PRINT;
            endcase
        end
    end

    // Physical row of the cursor line.
    assign phys_sum = {1'b0, top_reg} + {1'b0, cur_row_reg};
    assign phys     = (phys_sum >= (tcce_pkg::ROW_W + 1)'(tcce_pkg::ROWS))
                      ? tcce_pkg::ROW_W'(phys_sum - (tcce_pkg::ROW_W + 1)'(tcce_pkg::ROWS))
                      : phys_sum[tcce_pkg::ROW_W-1:0];

    assign col_dec    = cur_col_reg - 1'b1;
    assign wrap       = (cur_col_reg == COL_MAX);
    assign col_after  = wrap ? '0 : cur_col_reg + 1'b1;
    assign put_scroll = wrap && (cur_row_reg == ROW_MAX);
    assign tab_more   = is_tab_reg
                        && ((col_after % tcce_pkg::COL_W'(tcce_pkg::TAB_STOP)) != '0)
                        && ((tcnt_reg + 1'b1) < tcce_pkg::TCNT_W'(tcce_pkg::TAB_STOP));
    assign top_adv    = (top_reg == ROW_MAX) ? '0 : top_reg + 1'b1;
    assign emit       = cmd.put || cmd.bksp || cmd.scroll || cmd.clear;

    always_comb
    begin
        sts.cls        = cls;
        sts.out_free   = !ovalid_reg || out_ready;
        sts.col_zero   = (cur_col_reg == '0);
        sts.row_last   = (cur_row_reg == ROW_MAX);
        sts.put_scroll = put_scroll;
        sts.tab_more   = tab_more;
    end

    // Cursor state updates.
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        top_next     = top_reg;
        tcnt_next    = tcnt_reg;
        if (cmd.accept)
        begin
            tcnt_next = '0;
        end
        if (cmd.newline)
        begin
            cur_col_next = '0;
            if (cur_row_reg != ROW_MAX)
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
        if (cmd.cret)
        begin
            cur_col_next = '0;
        end
        if (cmd.bksp)
        begin
            cur_col_next = col_dec;
        end
        if (cmd.put)
        begin
            cur_col_next = col_after;
            tcnt_next    = tcnt_reg + 1'b1;
            if (wrap && !put_scroll)
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
        end
        if (cmd.scroll)
        begin
            top_next = top_adv;
        end
        if (cmd.clear)
        begin
            cur_row_next = '0;
            cur_col_next = '0;
            top_next     = '0;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
            tcnt_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            top_reg     <= top_next;
            tcnt_reg    <= tcnt_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Latch the item payload; tabs print as blanks.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            attr_reg   <= attr;
            is_tab_reg <= (cls == tcce_pkg::CLS_TAB);
            glyph_reg  <= (cls == tcce_pkg::CLS_TAB) ? tcce_pkg::CH_BLANK : char_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            okind_reg  <= tcce_pkg::KIND_CELL;
            orow_reg   <= phys;
            ocol_reg   <= cur_col_reg;
            oglyph_reg <= glyph_reg;
            oattr_reg  <= attr_reg;
            otop_reg   <= top_reg;
            olast_reg  <= !(put_scroll || tab_more);
        end
        else if (cmd.bksp)
        begin
            okind_reg  <= tcce_pkg::KIND_CELL;
            orow_reg   <= phys;
            ocol_reg   <= col_dec;
            oglyph_reg <= tcce_pkg::CH_BLANK;
            oattr_reg  <= attr_reg;
            otop_reg   <= top_reg;
            olast_reg  <= 1'b1;
        end
        else if (cmd.scroll)
        begin
            okind_reg  <= tcce_pkg::KIND_ROW;
            orow_reg   <= top_reg;
            ocol_reg   <= '0;
            oglyph_reg <= tcce_pkg::CH_BLANK;
            oattr_reg  <= attr_reg;
            otop_reg   <= top_adv;
            olast_reg  <= 1'b1;
        end
        else if (cmd.clear)
        begin
            okind_reg  <= tcce_pkg::KIND_SCREEN;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            oglyph_reg <= tcce_pkg::CH_BLANK;
            oattr_reg  <= tcce_pkg::CLEAR_ATTR;
            otop_reg   <= '0;
            olast_reg  <= 1'b1;
        end
    end

    assign out_valid = ovalid_reg;
    assign kind      = okind_reg;
    assign row       = orow_reg;
    assign col       = ocol_reg;
    assign glyph     = oglyph_reg;
    assign cell_attr = oattr_reg;
    assign top_row   = otop_reg;
    assign last      = olast_reg;

endmodule

// ===== src/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: controller, datapath and checks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  input   | in        | in_valid / in_ready  | op, char_code, attr
//  result  | out       | out_valid / out_ready| kind, row, col, glyph, cell_attr,
//          |           |                      | top_row, last
//
// An item is taken only while the controller is idle. Carriage return, newline
// without scroll and backspace at column zero finish in the accept cycle. Other
// items are accepted and then emit one result at a time: one cell for a backspace,
// one cell for a printable character plus a row scroll when the line wraps into a
// scroll, up to TAB_STOP blank cells for a tab plus a scroll when that tab wraps.
// Each result waits in a single output register; a stalled output holds the
// sequencer in place. Reset clears cursor, top-row offset and state.
module text_console_cursor_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [tcce_pkg::CHAR_W-1:0] char_code,
    input  logic [tcce_pkg::CHAR_W-1:0] attr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [tcce_pkg::ROW_W-1:0]  row,
    output logic [tcce_pkg::COL_W-1:0]  col,
    output logic [tcce_pkg::CHAR_W-1:0] glyph,
    output logic [tcce_pkg::CHAR_W-1:0] cell_attr,
    output logic [tcce_pkg::ROW_W-1:0]  top_row,
    output logic                        last
);

    // Commands from the sequencer, status back from the datapath.
    tcce_pkg::cmd_t cmd;
    tcce_pkg::sts_t sts;

    // Sequence one item's transactions: decode on accept, then one result per cycle while the output is free.
    tcce_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold cursor, top-row offset and the output register.
    tcce_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .char_code (char_code),
        .attr      (attr),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .glyph     (glyph),
        .cell_attr (cell_attr),
        .top_row   (top_row),
        .last      (last)
    );

    // Results always address the visible screen.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
                      && (col < tcce_pkg::COL_W'(tcce_pkg::COLS))
                      && (top_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS)))
        else $error("result outside screen bounds");

    // A screen clear is alone and homes the top line.
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == tcce_pkg::KIND_SCREEN) |-> last && (top_row == '0))
        else $error("screen clear not final or top row not home");

    // A row clear always closes its transaction group.
    a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == tcce_pkg::KIND_ROW) |-> last)
        else $error("row clear not final");

    // No new item while a non-final result is still pending.
    a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken in the middle of a result group");

endmodule

// ===== tb/tb_text_console_cursor_engine.sv =====
// Self-checking testbench for the text console cursor engine: cursor, wrap, tab and scroll.
module tb_text_console_cursor_engine;

    import tcce_pkg::*;

    localparam int ITEM_TARGET = 370;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 16;

    // One screen command as the block should emit it.
    typedef struct {
        kind_t             kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] glyph;
        logic [CHAR_W-1:0] cattr;
        logic [ROW_W-1:0]  top;
        logic              last;
    } screen_cmd_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              op        = 1'b0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [CHAR_W-1:0] attr      = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] glyph;
    logic [CHAR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  top_row;
    logic              last;

    // Predicted console state.
    logic [ROW_W-1:0]  cur_row = '0;
    logic [COL_W-1:0]  cur_col = '0;
    logic [ROW_W-1:0]  top_off = '0;

    screen_cmd_t pending_cmds[$];

    int fault_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    bit no_gaps     = 1'b0;
    int hold_req    = 0;

    text_console_cursor_engine i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .char_code (char_code),
        .attr      (attr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .glyph     (glyph),
        .cell_attr (cell_attr),
        .top_row   (top_row),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [ROW_W-1:0] screen_row();
        return ROW_W'((int'(top_off) + int'(cur_row)) % ROWS);
    endfunction

    function automatic void add_cmd(kind_t k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                    logic [CHAR_W-1:0] g, logic [CHAR_W-1:0] a);
        screen_cmd_t e;
        e.kind  = k;
        e.row   = r;
        e.col   = c;
        e.glyph = g;
        e.cattr = a;
        e.top   = top_off;
        e.last  = 1'b0;
        pending_cmds.push_back(e);
    endfunction

    // Free the old top row once the cursor falls off the bottom.
    function automatic void scroll_check(logic [CHAR_W-1:0] a);
        logic [ROW_W-1:0] freed;
        if (cur_row >= ROWS)
        begin
            freed   = top_off;
            top_off = ROW_W'((int'(freed) + 1) % ROWS);
            cur_row = ROW_W'(ROWS - 1);
            add_cmd(KIND_ROW, freed, '0, CH_BLANK, a);
        end
    endfunction

    function automatic void put_glyph(logic [CHAR_W-1:0] g, logic [CHAR_W-1:0] a);
        add_cmd(KIND_CELL, screen_row(), cur_col, g, a);
        cur_col = cur_col + 1'b1;
        if (cur_col >= COLS)
        begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        scroll_check(a);
    endfunction

    // Work out every command caused by one accepted transaction.
    function automatic void predict_console(logic o, logic [CHAR_W-1:0] c,
                                            logic [CHAR_W-1:0] a);
        int          base_n;
        int          n;
        screen_cmd_t tail;
        base_n = pending_cmds.size();
        if (o)
        begin
            cur_row = '0;
            cur_col = '0;
            top_off = '0;
            add_cmd(KIND_SCREEN, '0, '0, CH_BLANK, CLEAR_ATTR);
        end
        else
        begin
            case (c)
                CH_NEWLINE:
                begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                    scroll_check(a);
                end
                CH_RETURN:
                    cur_col = '0;
                CH_BACKSPACE:
                begin
                    if (cur_col != 0)
                    begin
                        cur_col = cur_col - 1'b1;
                        add_cmd(KIND_CELL, screen_row(), cur_col, CH_BLANK, a);
                    end
                end
                CH_TAB:
                begin
                    n = 0;
                    do
                    begin
                        put_glyph(CH_BLANK, a);
                        n++;
                    end
                    while ((int'(cur_col) % TAB_STOP) != 0 && n < TAB_STOP);
                end
                default:
                    put_glyph(c, a);
            endcase
        end
        if (pending_cmds.size() > base_n)
        begin
            tail      = pending_cmds.pop_back();
            tail.last = 1'b1;
            pending_cmds.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [CHAR_W-1:0] any_glyph();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] any_attr();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Offer one transaction and hold it until accepted; insert burst gaps before it.
    task automatic push_item(input logic o, input logic [CHAR_W-1:0] c,
                             input logic [CHAR_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        op        <= o;
        char_code <= c;
        attr      <= a;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_console(o, c, a);
        items_sent++;
    endtask

    // Drop valid and wait for every predicted command to come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
    endtask

    task automatic test_controls();
        push_item(1'b1, 8'hFF, 8'hFF);          // clear ignores char and attr
        push_item(1'b0, CH_BACKSPACE, 8'h5A);   // backspace at column zero
        push_item(1'b0, 8'h00, 8'h00);
        push_item(1'b0, 8'hFF, 8'hFF);
        push_item(1'b0, 8'h7F, 8'h80);
        push_item(1'b0, 8'h80, 8'h7F);
        push_item(1'b0, 8'h0B, 8'h01);
        push_item(1'b0, 8'h0E, 8'hFE);
        push_item(1'b0, CH_BACKSPACE, 8'hA5);   // blank the previous cell
        push_item(1'b0, CH_RETURN, 8'h33);
        push_item(1'b0, CH_TAB, 8'h1E);         // full stop of blanks from column 0
        push_item(1'b0, 8'h41, 8'h2F);
        push_item(1'b0, CH_TAB, 8'hC3);         // partial stop
        push_item(1'b0, CH_NEWLINE, 8'h44);     // move only
        push_item(1'b0, CH_NEWLINE, 8'hBB);
        push_item(1'b1, 8'h00, 8'h00);
    endtask

    // Wrap by tab and by glyph, walk to the bottom, then scroll on newline and on tab.
    task automatic test_wrap_scroll();
        repeat (10) push_item(1'b0, CH_TAB, any_attr());
        repeat (9) push_item(1'b0, CH_TAB, any_attr());
        repeat (8) push_item(1'b0, any_glyph(), any_attr());
        while (cur_row < ROWS - 1) push_item(1'b0, CH_NEWLINE, any_attr());
        push_item(1'b0, CH_NEWLINE, any_attr());
        repeat (10) push_item(1'b0, CH_TAB, any_attr());
    endtask

    // Stall the result side for a long stretch while input keeps coming, then pause.
    task automatic test_backpressure();
        no_gaps    = 1'b1;
        burst_left = 0;
        hold_req   = HOLD_CYCLES;
        repeat (20) push_item(1'b0, any_glyph(), any_attr());
        repeat (3) push_item(1'b0, CH_TAB, any_attr());
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        int pick;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // text line, now and then long enough to wrap
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 85)
                                                  : $urandom_range(0, 8);
                repeat (len) push_item(1'b0, any_glyph(), any_attr());
                case ($urandom_range(0, 3))
                    0: push_item(1'b0, CH_RETURN, any_attr());
                    1: ;
                    default: push_item(1'b0, CH_NEWLINE, any_attr());
                endcase
            end
            else if (pick < 55)
            begin
                repeat ($urandom_range(1, 11))
                begin
                    if ($urandom_range(0, 4) == 0)
                        push_item(1'b0, any_glyph(), any_attr());
                    push_item(1'b0, CH_TAB, any_attr());
                end
            end
            else if (pick < 67)
                repeat ($urandom_range(1, 5)) push_item(1'b0, CH_BACKSPACE, any_attr());
            else if (pick < 82)
                repeat ($urandom_range(1, 4)) push_item(1'b0, CH_NEWLINE, any_attr());
            else if (pick < 84)
                push_item(1'b1, any_glyph(), any_attr());
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_item(($urandom_range(0, 15) == 0), CHAR_W'($urandom_range(0, 255)),
                              any_attr());
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Stall on changing patterns; honor a long hold-off request when one is posted.
    initial
    begin : result_stall
        int hold_left;
        int mode;
        int span_left;
        int phase;
        hold_left = 0;
        span_left = 0;
        mode      = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (span_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    span_left = $urandom_range(5, 80);
                    phase     = 0;
                end
                span_left--;
                phase++;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= (phase % 4) != 0;
                    default: out_ready <= (phase % 7) < 2;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        screen_cmd_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: unexpected result kind=%0d row=%0d col=%0d glyph=%02h",
                             $time, kind, row, col, glyph);
            end
            else
            begin
                e = pending_cmds.pop_front();
                if (kind !== e.kind || row !== e.row || col !== e.col || glyph !== e.glyph ||
                    cell_attr !== e.cattr || top_row !== e.top || last !== e.last)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("%0t: mismatch exp kind=%0d row=%0d col=%0d glyph=%02h",
                                 $time, e.kind, e.row, e.col, e.glyph);
                        $display("    exp attr=%02h top=%0d last=%0b",
                                 e.cattr, e.top, e.last);
                        $display("    got kind=%0d row=%0d col=%0d glyph=%02h",
                                 kind, row, col, glyph);
                        $display("    got attr=%02h top=%0d last=%0b",
                                 cell_attr, top_row, last);
                    end
                end
            end
        end
    end

    // Abort when neither channel moves a transaction for too long.
    initial
    begin : idle_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[text_console_cursor_engine] ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_controls();
        test_wrap_scroll();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_cmds.size() == 0)
            $display("[text_console_cursor_engine] OK");
        else
            $display("[text_console_cursor_engine] ERROR");
        $finish;
    end

endmodule
